FILE: hw/rtl/mpc_pkg.sv
// shared types and constants of the merge path corank search
`default_nettype none

package mpc_pkg;

    localparam int LEN_W      = 11;
    localparam int IDX_W      = 10;
    localparam int KEY_W      = 64;
    localparam int POS_W      = 12;
    localparam int MAX_ROUNDS = 64;
    localparam int ROUND_W    = $clog2(MAX_ROUNDS);

    localparam logic [1:0] ACT_WR_A  = 2'd0;
    localparam logic [1:0] ACT_WR_B  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic CFG_LEN_A = 1'b0;
    localparam logic CFG_LEN_B = 1'b1;

    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] key_value;
        logic [POS_W-1:0]        query_position;
    } t_in_word;

    typedef struct packed {
        logic [LEN_W-1:0] a_count;
        logic [LEN_W-1:0] b_count;
    } t_out_word;

    // key positions that one bisection round looks at
    typedef struct packed {
        logic [LEN_W-1:0] a_prev;
        logic [LEN_W-1:0] a_cur;
        logic [LEN_W-1:0] b_prev;
        logic [LEN_W-1:0] b_cur;
    } t_rd_addr;

    typedef struct packed {
        logic signed [KEY_W-1:0] a_prev;
        logic signed [KEY_W-1:0] a_cur;
        logic signed [KEY_W-1:0] b_prev;
        logic signed [KEY_W-1:0] b_cur;
    } t_rd_keys;

endpackage

`default_nettype wire

FILE: hw/rtl/mpc_keymem.sv
// key memory: one write port, two registered read ports
`default_nettype none

module mpc_keymem import mpc_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [KEY_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr0,
    input  wire logic [AW-1:0]    i_raddr1,
    output logic      [KEY_W-1:0] o_rdata0,
    output logic      [KEY_W-1:0] o_rdata1
);

    logic [KEY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mpc_search.sv
// bisection sequencer for the corank pair, with the result register
`default_nettype none

module mpc_search import mpc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LEN_W-1:0] i_la,
    input  wire logic [LEN_W-1:0] i_lb,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_word,
    output t_rd_addr              o_rd_addr,
    input  wire t_rd_keys         i_rd_keys
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [LEN_W-1:0]   r_j, n_j, r_k, n_k;
    logic [LEN_W-1:0]   r_j_low, n_j_low, r_k_low, n_k_low;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic [POS_W-1:0] w_sum, w_pos;
    logic [LEN_W-1:0] w_j0, w_k0, w_j_low0;
    logic [POS_W-1:0] w_span_up, w_span_dn;
    logic [LEN_W-1:0] w_delta_up, w_delta_dn;
    logic             w_step_up, w_step_dn, w_out_free, w_start;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_start    = i_in_valid && o_in_ready && (i_in_word.action == ACT_QUERY);
    assign w_out_free = !r_out_valid || i_out_ready;

    // start point of the search, position clamped to the merged length
    assign w_sum    = {1'b0, i_la} + {1'b0, i_lb};
    assign w_pos    = (i_in_word.query_position > w_sum) ? w_sum : i_in_word.query_position;
    assign w_j0     = (w_pos < {1'b0, i_la}) ? w_pos[LEN_W-1:0] : i_la;
    assign w_k0     = LEN_W'(w_pos - {1'b0, w_j0});
    assign w_j_low0 = (w_pos > {1'b0, i_lb}) ? LEN_W'(w_pos - {1'b0, i_lb}) : '0;

    assign o_rd_addr.a_prev = r_j - LEN_W'(1);
    assign o_rd_addr.a_cur  = r_j;
    assign o_rd_addr.b_prev = r_k - LEN_W'(1);
    assign o_rd_addr.b_cur  = r_k;

    // A first on equal keys
    assign w_step_up = (r_j != '0) && (r_k < i_lb)
                       && ($signed(i_rd_keys.a_prev) > $signed(i_rd_keys.b_cur));
    assign w_step_dn = (r_k != '0) && (r_j < i_la)
                       && !($signed(i_rd_keys.a_cur) > $signed(i_rd_keys.b_prev));

    // ceiling halving of the remaining span
    assign w_span_up  = {1'b0, r_j} - {1'b0, r_j_low} + POS_W'(1);
    assign w_span_dn  = {1'b0, r_k} - {1'b0, r_k_low} + POS_W'(1);
    assign w_delta_up = w_span_up[LEN_W:1];
    assign w_delta_dn = w_span_dn[LEN_W:1];

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_k         = r_k;
        n_j_low     = r_j_low;
        n_k_low     = r_k_low;
        n_round     = r_round;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_j     = w_j0;
                    n_k     = w_k0;
                    n_j_low = w_j_low0;
                    n_k_low = w_k0;
                    n_round = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (w_step_up) begin
                    n_k_low = r_k;
                    n_j     = r_j - w_delta_up;
                    n_k     = r_k + w_delta_up;
                end else if (w_step_dn) begin
                    n_j_low = r_j;
                    n_j     = r_j + w_delta_dn;
                    n_k     = r_k - w_delta_dn;
                end
                if ((w_step_up || w_step_dn) && (r_round != ROUND_W'(MAX_ROUNDS - 1))) begin
                    n_round = r_round + ROUND_W'(1);
                    n_state = ST_READ;
                end else if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_word.a_count = n_j;
                    n_out_word.b_count = n_k;
                    n_state            = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_word.a_count = r_j;
                    n_out_word.b_count = r_k;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_k        <= n_k;
        r_j_low    <= n_j_low;
        r_k_low    <= n_k_low;
        r_round    <= n_round;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: hw/rtl/merge_path_corank.sv
// top level: length registers, key memories A and B, corank search
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------
//  input    | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  output   | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// a key write is taken while the search is idle; a query runs bisection rounds
// (memory read, then compare and step), at most 64 rounds;
// the result sits in an output register, so a stalled output holds one answer
// while key writes go on; a second query is searched, but then holds the input
// stalled until that answer can leave
// reset is synchronous and clears the lengths and the control state only
`default_nettype none

module merge_path_corank import mpc_pkg::*; #(
    parameter int DEPTH_A = 1024,
    parameter int DEPTH_B = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_word,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [LEN_W-1:0] i_cfg_data
);

    localparam int AW_A = $clog2(DEPTH_A);
    localparam int AW_B = $clog2(DEPTH_B);
    localparam logic [16:0] DEPTH_A_V = 17'(DEPTH_A);
    localparam logic [16:0] DEPTH_B_V = 17'(DEPTH_B);

    logic [LEN_W-1:0] r_len_a, r_len_b;
    logic [LEN_W-1:0] w_la, w_lb;
    logic             w_in_ready, w_write, w_we_a, w_we_b;
    logic [31:0]      w_widx;
    logic [31:0]      w_ra_prev, w_ra_cur, w_rb_prev, w_rb_cur;
    t_rd_addr         w_rd_addr;
    t_rd_keys         w_rd_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEN_A: r_len_a <= i_cfg_data;
                CFG_LEN_B: r_len_b <= i_cfg_data;
                default:   r_len_a <= r_len_a;
            endcase
        end
    end

    // lengths beyond the memory depth count as the depth
    assign w_la = (17'(r_len_a) < DEPTH_A_V) ? r_len_a : DEPTH_A_V[LEN_W-1:0];
    assign w_lb = (17'(r_len_b) < DEPTH_B_V) ? r_len_b : DEPTH_B_V[LEN_W-1:0];

    assign w_write = i_in_valid && w_in_ready;
    assign w_widx  = 32'(i_in_word.entry_index);
    assign w_we_a  = w_write && (i_in_word.action == ACT_WR_A) && (w_widx < 32'(DEPTH_A));
    assign w_we_b  = w_write && (i_in_word.action == ACT_WR_B) && (w_widx < 32'(DEPTH_B));

    assign w_ra_prev = 32'(w_rd_addr.a_prev);
    assign w_ra_cur  = 32'(w_rd_addr.a_cur);
    assign w_rb_prev = 32'(w_rd_addr.b_prev);
    assign w_rb_cur  = 32'(w_rd_addr.b_cur);

    mpc_keymem #(.DEPTH(DEPTH_A)) u_keys_a (
        .i_clk    (i_clk),
        .i_we     (w_we_a),
        .i_waddr  (w_widx[AW_A-1:0]),
        .i_wdata  (i_in_word.key_value),
        .i_raddr0 (w_ra_prev[AW_A-1:0]),
        .i_raddr1 (w_ra_cur[AW_A-1:0]),
        .o_rdata0 (w_rd_keys.a_prev),
        .o_rdata1 (w_rd_keys.a_cur)
    );

    mpc_keymem #(.DEPTH(DEPTH_B)) u_keys_b (
        .i_clk    (i_clk),
        .i_we     (w_we_b),
        .i_waddr  (w_widx[AW_B-1:0]),
        .i_wdata  (i_in_word.key_value),
        .i_raddr0 (w_rb_prev[AW_B-1:0]),
        .i_raddr1 (w_rb_cur[AW_B-1:0]),
        .o_rdata0 (w_rd_keys.b_prev),
        .o_rdata1 (w_rd_keys.b_cur)
    );

    mpc_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_la        (w_la),
        .i_lb        (w_lb),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (w_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_rd_addr   (w_rd_addr),
        .i_rd_keys   (w_rd_keys)
    );

    assign o_in_ready = w_in_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/mpc_checker.sv
// port-level checks of the corank block, bound to the top level
`default_nettype none

module mpc_checker import mpc_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_word         i_in_word,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_word        o_out_word
);

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

    // a query keeps the block busy for at least the first memory read
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in_word.action == ACT_QUERY)) |=> !o_in_ready)
        else $error("input taken during a search");

    // key writes and unused actions leave the input ready again in the next cycle
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in_word.action != ACT_QUERY)) |=> o_in_ready)
        else $error("write word stalled the input");

endmodule

bind merge_path_corank mpc_checker u_mpc_checker (.*);

`default_nettype wire
